// File: rtl/sparse_table_range_min_top_macros.svh
// ----------------------------------------------------------------------------
// sparse table range minimum - assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SPARSE_TABLE_RANGE_MIN_TOP_MACROS_SVH
`define SPARSE_TABLE_RANGE_MIN_TOP_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define STRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define STRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/strm_pkg.sv
// ----------------------------------------------------------------------------
// strm_pkg
// sizes, command and status codes and helpers of the range minimum engine
// ----------------------------------------------------------------------------
`default_nettype none

package strm_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVEL_COUNT  = 11;

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W  = $clog2(LEVEL_COUNT);
    localparam int K_W    = $clog2(CNT_W);
    localparam int SPAN_W = LEVEL_COUNT - 1;
    localparam int ADDR_W = $clog2(LEVEL_COUNT * MAX_ELEMENTS);

    // stream payload widths
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int START_W      = 10;
    localparam int END_W        = 11;
    localparam int S_TDATA_W    = 56;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // flat address of entry idx in level lvl
    function automatic logic [ADDR_W-1:0] strm_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
        strm_addr = ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(idx);
    endfunction

    // priority encoder: position of the highest set bit
    function automatic logic [K_W-1:0] strm_floor_log2(input logic [CNT_W-1:0] x);
        strm_floor_log2 = '0;
        for (int j = 0; j < CNT_W; j++) begin
            if (x[j]) begin
                strm_floor_log2 = K_W'(j);
            end
        end
    endfunction

    function automatic word_t strm_min(input word_t a, input word_t b);
        strm_min = (a < b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sparse_table_range_min_top.sv
// ----------------------------------------------------------------------------
// sparse_table_range_min_top
// static range minimum engine over signed 32-bit values (sparse table)
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream with the command code in s_tuser; every
// command returns exactly one result transfer on the m_ stream, with the
// status code in m_tuser. Append and the unused code answer in the cycle
// after the transfer, as do queries that are refused (not built, empty or
// out of range). A valid query steps through floor log2 of the length with
// the first read of the table, the second read, then the compare. Build
// walks every level with one shared compare unit and the single read port
// of the table: for each entry a bound check with the first read, the
// second read, then the compare and write back. The table has no clearing
// pass: queries only ever read entries that have been written. Input is
// refused while a command is in work or a result waits untaken.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_table_range_min_top
    import strm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // command stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // element_value [31:0], range_start [41:32], range_end [52:42], zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // command [1:0]
    input  wire logic [CMD_W-1:0]      s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // range_minimum [31:0]
    output logic [DATA_W-1:0]          m_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]        m_tuser
);

    localparam int SUM_W = ((CNT_W > SPAN_W) ? CNT_W : SPAN_W) + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QLOG = 3'd1;   // priority encode, first read
    localparam logic [2:0] S_QRB  = 3'd2;   // second query read
    localparam logic [2:0] S_QCMP = 3'd3;   // compare, emit result
    localparam logic [2:0] S_BCHK = 3'd4;   // bound check, first build read
    localparam logic [2:0] S_BRB  = 3'd5;   // second build read
    localparam logic [2:0] S_BWR  = 3'd6;   // compare, write back

    // table: one word per level and element
    word_t mem [0:LEVEL_COUNT*MAX_ELEMENTS-1];

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 built_reg, built_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [LVL_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    word_t                acc_reg, acc_next;
    word_t                rd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    word_t                out_data_reg, out_data_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    // table port controls
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    word_t                wr_data;

    // input fields
    logic [CMD_W-1:0]     in_cmd;
    word_t                in_value;
    logic [START_W-1:0]   in_start;
    logic [END_W-1:0]     in_end;
    logic                 in_xfer;

    // shared datapath terms
    logic [SUM_W-1:0]     build_sum;
    logic [CNT_W-1:0]     q_len;
    logic [K_W-1:0]       q_k;
    logic [CNT_W-1:0]     q_second;
    word_t                min_val;

    assign in_cmd   = s_tuser;
    assign in_value = word_t'(s_tdata[31:0]);
    assign in_start = s_tdata[41:32];
    assign in_end   = s_tdata[52:42];

    // accept only when idle and the output register is free or draining
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    assign build_sum = SUM_W'(idx_reg) + SUM_W'(span_reg);
    assign q_len     = hi_reg - CNT_W'(lo_reg);
    assign q_k       = strm_floor_log2(q_len);
    assign q_second  = hi_reg - (CNT_W'(1) << k_reg);
    // the one compare unit, shared by build and query
    assign min_val   = strm_min(acc_reg, rd_data_reg);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        built_next      = built_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        span_next       = span_reg;
        k_next          = k_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = strm_addr('0, IDX_W'(count_reg));
        wr_data         = in_value;

        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (in_cmd)
                        CMD_APPEND: begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            if (32'(count_reg) >= MAX_ELEMENTS) begin
                                out_status_next = STAT_FULL;
                            end else begin
                                out_status_next = STAT_OK;
                                wr_en           = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                built_next      = 1'b0;
                            end
                        end
                        CMD_BUILD: begin
                            lvl_next   = LVL_W'(1);
                            idx_next   = '0;
                            span_next  = SPAN_W'(1);
                            state_next = S_BCHK;
                        end
                        CMD_QUERY: begin
                            out_data_next = '0;
                            if (!built_reg) begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_NOT_BUILT;
                            end else if ((32'(in_start) >= 32'(in_end)) ||
                                         (32'(in_end) > 32'(count_reg))) begin
                                out_valid_next  = 1'b1;
                                out_status_next = STAT_RANGE;
                            end else begin
                                lo_next    = IDX_W'(in_start);
                                hi_next    = CNT_W'(in_end);
                                state_next = S_QLOG;
                            end
                        end
                        default: begin
                            out_valid_next  = 1'b1;
                            out_data_next   = '0;
                            out_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_QLOG: begin
                if (32'(q_k) >= LEVEL_COUNT) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_status_next = STAT_RANGE;
                    state_next      = S_IDLE;
                end else begin
                    k_next     = LVL_W'(q_k);
                    rd_addr    = strm_addr(LVL_W'(q_k), lo_reg);
                    state_next = S_QRB;
                end
            end
            S_QRB: begin
                acc_next   = rd_data_reg;
                rd_addr    = strm_addr(k_reg, IDX_W'(q_second));
                state_next = S_QCMP;
            end
            S_QCMP: begin
                out_valid_next  = 1'b1;
                out_data_next   = min_val;
                out_status_next = STAT_OK;
                state_next      = S_IDLE;
            end
            S_BCHK: begin
                if (build_sum < SUM_W'(count_reg)) begin
                    rd_addr    = strm_addr(lvl_reg - LVL_W'(1), idx_reg);
                    state_next = S_BRB;
                end else if (32'(lvl_reg) == LEVEL_COUNT - 1) begin
                    built_next      = 1'b1;
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_status_next = STAT_OK;
                    state_next      = S_IDLE;
                end else begin
                    lvl_next  = lvl_reg + LVL_W'(1);
                    span_next = span_reg << 1;
                    idx_next  = '0;
                end
            end
            S_BRB: begin
                acc_next   = rd_data_reg;
                rd_addr    = strm_addr(lvl_reg - LVL_W'(1), IDX_W'(build_sum));
                state_next = S_BWR;
            end
            S_BWR: begin
                wr_en      = 1'b1;
                wr_addr    = strm_addr(lvl_reg, idx_reg);
                wr_data    = min_val;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_BCHK;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and loop registers, no reset needed
    always_ff @(posedge aclk) begin
        lvl_reg        <= lvl_next;
        idx_reg        <= idx_next;
        span_reg       <= span_next;
        k_reg          <= k_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        acc_reg        <= acc_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// File: rtl/strm_checker.sv
// ----------------------------------------------------------------------------
// strm_checker
// port-level checks of the range minimum engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_table_range_min_top_macros.svh"

module strm_checker
    import strm_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [CMD_W-1:0]      s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [DATA_W-1:0]     m_tdata,
    input wire logic [STATUS_W-1:0]   m_tuser
);

    // no new command while a result is stuck on the output
    `STRM_ASSERT_NOW(a_no_accept_when_blocked,
        s_tready && m_tvalid,
        m_tready,
        "input taken while result stalled")

    // an append answers in the next cycle with ok or store full and zero data
    `STRM_ASSERT_NEXT(a_append_answer,
        s_tvalid && s_tready && (s_tuser == CMD_APPEND),
        m_tvalid && (m_tdata == '0) && ((m_tuser == STAT_OK) || (m_tuser == STAT_FULL)),
        "bad append result")

    // refused results carry zero data
    `STRM_ASSERT_NOW(a_zero_on_error,
        m_tvalid && (m_tuser != STAT_OK),
        m_tdata == '0,
        "nonzero data with error status")

    // a stalled result holds
    `STRM_ASSERT_NEXT(a_result_hold,
        m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result changed while stalled")

endmodule

bind sparse_table_range_min_top strm_checker u_strm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sparse table range minimum engine
// ----------------------------------------------------------------------------
// A command list is built up front: a short directed opening, then rounds of
// appends, a build and a spread of queries, until the store is full, then
// appends that the full store refuses. A burst driver feeds the s_ stream. A
// shadow table follows every accepted command and queues the answer it
// expects. The monitor takes results under a changing stall pattern, with an
// occasional long hold, and compares each one with the oldest expected answer.
// ----------------------------------------------------------------------------

module tb_top;
    import strm_pkg::*;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        word_t              value;
        logic [START_W-1:0] lo;
        logic [END_W-1:0]   hi;
        bit                 drain_first;    // wait for every answer before offering
    } command_t;

    typedef struct {
        word_t               minimum;
        logic [STATUS_W-1:0] status;
    } answer_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // element_value [31:0], range_start [41:32], range_end [52:42], zero pad
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // command [1:0]
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // range_minimum [31:0]
    logic [DATA_W-1:0]    m_tdata;
    // status [1:0]
    logic [STATUS_W-1:0]  m_tuser;

    sparse_table_range_min_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // shadow of the engine
    word_t       shadow_tbl [LEVEL_COUNT][MAX_ELEMENTS];
    int unsigned shadow_count = 0;
    bit          shadow_built = 1'b0;

    command_t    command_q [$];
    answer_t     answer_q [$];
    int unsigned gen_count  = 0;
    bit          drain_next = 1'b0;
    int unsigned fail_cnt   = 0;

    // driver state
    command_t    cur_cmd;
    bit          offering;
    bit          may_offer;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    // monitor state
    answer_t     want;
    bit          take;
    int unsigned rx_mode    = 0;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    int unsigned since_hold = 0;

    initial forever #5 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic word_t lesser(input word_t a, input word_t b);
        return (a < b) ? a : b;
    endfunction

    // advance the shadow table by one command and queue its answer
    task automatic apply_command(input command_t it);
        answer_t     ans;
        int unsigned t, len, k;
        ans.minimum = '0;
        ans.status  = STAT_OK;
        case (it.cmd)
            CMD_APPEND: begin
                if (shadow_count >= MAX_ELEMENTS) begin
                    ans.status = STAT_FULL;
                end else begin
                    shadow_tbl[0][shadow_count] = it.value;
                    shadow_count++;
                    shadow_built = 1'b0;
                end
            end
            CMD_BUILD: begin
                for (int b = 1; b < LEVEL_COUNT; b++) begin
                    t = 1 << (b - 1);
                    for (int i = 0; i + t < shadow_count; i++) begin
                        shadow_tbl[b][i] = lesser(shadow_tbl[b-1][i], shadow_tbl[b-1][i+t]);
                    end
                end
                shadow_built = 1'b1;
            end
            CMD_QUERY: begin
                if (!shadow_built) begin
                    ans.status = STAT_NOT_BUILT;
                end else if (it.lo >= it.hi || it.hi > shadow_count) begin
                    ans.status = STAT_RANGE;
                end else begin
                    len = it.hi - it.lo;
                    k = 0;
                    while ((len >> (k + 1)) != 0) k++;
                    if (k >= LEVEL_COUNT) begin
                        ans.status = STAT_RANGE;
                    end else begin
                        ans.minimum = lesser(shadow_tbl[k][it.lo],
                                             shadow_tbl[k][it.hi - (1 << k)]);
                    end
                end
            end
            default: ;
        endcase
        answer_q.push_back(ans);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: rand_word = 32'h8000_0000;
                    1: rand_word = 32'h7fff_ffff;
                    2: rand_word = 32'hffff_ffff;
                    default: rand_word = '0;
                endcase
            end
            // narrow spread so that ties turn up
            1, 2: rand_word = int'($urandom_range(0, 100)) - 50;
            default: rand_word = $urandom;
        endcase
    endfunction

    task automatic add_item(input logic [CMD_W-1:0] cmd, input word_t value,
                            input int unsigned lo, input int unsigned hi);
        command_t it;
        it.cmd         = cmd;
        it.value       = value;
        it.lo          = START_W'(lo);
        it.hi          = END_W'(hi);
        it.drain_first = drain_next;
        drain_next     = 1'b0;
        command_q.push_back(it);
        if (cmd == CMD_APPEND && gen_count < MAX_ELEMENTS) gen_count++;
    endtask

    task automatic add_random_query();
        int unsigned pick, len, lo, hi;
        pick = $urandom_range(0, 99);
        if (pick < 85 && gen_count > 0) begin
            case ($urandom_range(0, 7))
                0: len = 1;
                1: len = gen_count;
                2, 3: begin
                    len = 1 << $urandom_range(0, LEVEL_COUNT - 1);
                    while (len > gen_count) len = len >> 1;
                end
                default: len = $urandom_range(1, gen_count);
            endcase
            lo = $urandom_range(0, gen_count - len);
            hi = lo + len;
        end else if (pick < 90) begin
            // empty or reversed range
            lo = $urandom_range(0, MAX_ELEMENTS - 1);
            hi = $urandom_range(0, lo);
        end else if (pick < 95) begin
            // end past the loaded elements
            hi = $urandom_range(gen_count + 1, (1 << END_W) - 1);
            lo = $urandom_range(0, (hi - 1 < MAX_ELEMENTS - 1) ? hi - 1 : MAX_ELEMENTS - 1);
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
        add_item(CMD_QUERY, $urandom, lo, hi);
    endtask

    initial begin
        int unsigned batch, nq;

        // empty engine: not built, unused code, build over nothing, an empty range and a range past the end
        add_item(CMD_QUERY, $urandom, 0, 1);
        add_item(CMD_UNUSED, $urandom, $urandom, $urandom);
        add_item(CMD_BUILD, $urandom, $urandom, $urandom);
        add_item(CMD_QUERY, $urandom, 0, 0);
        add_item(CMD_QUERY, $urandom, 0, 1);
        // value extremes
        add_item(CMD_APPEND, 32'h8000_0000, 0, 0);
        add_item(CMD_APPEND, 32'h7fff_ffff, 1023, 2047);
        add_item(CMD_APPEND, 32'hffff_ffff, 0, 0);
        add_item(CMD_APPEND, 32'h0000_0000, 0, 0);
        add_item(CMD_APPEND, 32'h0000_0001, 0, 0);
        add_item(CMD_APPEND, 32'h8000_0001, 0, 0);
        // appended since the last build
        add_item(CMD_QUERY, $urandom, 0, 6);
        drain_next = 1'b1;
        add_item(CMD_BUILD, $urandom, $urandom, $urandom);
        add_item(CMD_QUERY, $urandom, 0, 6);
        add_item(CMD_QUERY, $urandom, 1, 2);
        add_item(CMD_QUERY, $urandom, 2, 3);
        add_item(CMD_QUERY, $urandom, 1, 6);
        add_item(CMD_QUERY, $urandom, 3, 5);
        add_item(CMD_QUERY, $urandom, 5, 5);
        add_item(CMD_QUERY, $urandom, 4, 3);
        add_item(CMD_QUERY, $urandom, 0, 7);
        add_item(CMD_QUERY, $urandom, 1023, 2047);
        // append after build drops the levels until the next build
        add_item(CMD_APPEND, 5, 0, 0);
        add_item(CMD_QUERY, $urandom, 0, 1);
        add_item(CMD_BUILD, $urandom, $urandom, $urandom);
        add_item(CMD_QUERY, $urandom, 0, 7);

        // rounds of load, build and query until the store is full
        while (gen_count < MAX_ELEMENTS) begin
            batch = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                                : $urandom_range(60, 160);
            drain_next = $urandom_range(0, 1);
            for (int j = 0; j < batch && gen_count < MAX_ELEMENTS; j++) begin
                add_item(CMD_APPEND, rand_word(), $urandom, $urandom);
                if ($urandom_range(0, 59) == 0) add_random_query();
                if ($urandom_range(0, 119) == 0)
                    add_item(CMD_UNUSED, $urandom, $urandom, $urandom);
            end
            add_item(CMD_BUILD, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 7) == 0) add_item(CMD_BUILD, $urandom, $urandom, $urandom);
            nq = $urandom_range(2, 6);
            for (int j = 0; j < nq; j++) begin
                add_random_query();
                if ($urandom_range(0, 39) == 0)
                    add_item(CMD_UNUSED, $urandom, $urandom, $urandom);
            end
        end
        // full store refuses appends and keeps its levels
        for (int j = 0; j < 6; j++) begin
            add_item(CMD_APPEND, rand_word(), $urandom, $urandom);
            add_random_query();
            add_random_query();
        end
        add_item(CMD_QUERY, $urandom, 0, MAX_ELEMENTS);
        add_item(CMD_QUERY, $urandom, 0, MAX_ELEMENTS + 1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (command_q.size() != 0 || s_tvalid) @(negedge aclk);
        while (answer_q.size() != 0) @(negedge aclk);
        // catch any stray result after the last one
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // command driver: bursts with gaps, optional wait for all answers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                apply_command(cur_cmd);
                offering = 1'b0;
            end
            if (!offering) begin
                may_offer = (command_q.size() != 0);
                if (may_offer && command_q[0].drain_first &&
                    (answer_q.size() != 0 || m_tvalid)) begin
                    may_offer = 1'b0;
                end
                if (gap_left != 0) begin
                    gap_left--;
                end else if (may_offer) begin
                    cur_cmd = command_q.pop_front();
                    s_tdata <= S_TDATA_W'({cur_cmd.hi, cur_cmd.lo, cur_cmd.value});
                    s_tuser <= cur_cmd.cmd;
                    offering = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            s_tvalid <= offering;
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t result with none expected: actual minimum %0d status %0d",
                             $time, $signed(m_tdata), m_tuser);
                    fail_cnt++;
                end else begin
                    want = answer_q.pop_front();
                    if (m_tdata !== want.minimum) begin
                        $display("%0t minimum mismatch: expected %0d actual %0d",
                                 $time, want.minimum, $signed(m_tdata));
                        fail_cnt++;
                    end
                    if (m_tuser !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fail_cnt++;
                    end
                end
            end

            since_hold++;
            if (mode_left != 0) begin
                mode_left--;
            end else begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 160);
            end
            if (hold_left != 0) begin
                hold_left--;
                take = 1'b0;
            end else if (since_hold > 4000 && m_tvalid) begin
                // long hold-off so the engine backs up into the command stream
                hold_left  = 400;
                since_hold = 0;
                take       = 1'b0;
            end else begin
                case (rx_mode)
                    0: take = 1'b1;
                    1: take = $urandom_range(0, 1);
                    2: take = (since_hold % 3 == 0);
                    default: take = ($urandom_range(0, 7) != 0);
                endcase
            end
            m_tready <= take;
        end
    end

endmodule
